FILE: rtl/ctins_pkg.sv
// shared codes and field widths for the cuckoo table insert unit
`default_nettype none

package ctins_pkg;

  // action codes carried by an input item
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_KICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_BYTE = 1'b1;
  localparam logic [15:0] MAX_KICKS_RESET = 16'd1024;

  // fixed payload widths of the channels
  localparam int ADDR_W      = 10;
  localparam int FIELD_ID_W  = 16;
  localparam int FIELD_VAL_W = 64;
  localparam int ROUND_W     = 16;

endpackage

`default_nettype wire

FILE: rtl/ctins_if.sv
// item channels of the cuckoo table insert unit
`default_nettype none

interface ctins_in_if import ctins_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             action;
  logic [FIELD_ID_W-1:0]  element_id;
  logic [ADDR_W-1:0]      address_0;
  logic [ADDR_W-1:0]      address_1;
  logic [ADDR_W-1:0]      address_2;
  logic [FIELD_VAL_W-1:0] value;
  logic [ADDR_W-1:0]      bin_index;

  modport source (output valid, action, element_id, address_0, address_1, address_2,
                  value, bin_index, input ready);
  modport sink (input valid, action, element_id, address_0, address_1, address_2,
                value, bin_index, output ready);
endinterface

interface ctins_out_if import ctins_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   insert_ok;
  logic [FIELD_ID_W-1:0]  dropped_id;
  logic                   occupied;
  logic [FIELD_ID_W-1:0]  stored_id;
  logic [FIELD_VAL_W-1:0] stored_value;

  modport source (output valid, insert_ok, dropped_id, occupied, stored_id, stored_value,
                  input ready);
  modport sink (input valid, insert_ok, dropped_id, occupied, stored_id, stored_value,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/ctins_front.sv
// front end: takes items, reduces candidate addresses into the table, packs queue entries
`default_nettype none

module ctins_front import ctins_pkg::*; #(
  parameter int TABLE_BINS = 1024,
  parameter int ID_BITS    = 16,
  parameter int VALUE_BITS = 64,
  parameter int IDX_W      = 10,
  parameter int ENTRY_W    = 3 + 4 * IDX_W + ID_BITS + VALUE_BITS
) (
  input  wire                clk,
  input  wire                rst,
  ctins_in_if.sink           in_ch,
  output logic               push,
  output logic [ENTRY_W-1:0] push_data,
  input  wire                full
);

  // addresses above the table wrap by reciprocal multiply, exact for 10-bit inputs whose quotient fits in 8 bits
  localparam bit REDUCE = TABLE_BINS < 1024;
  localparam int RECIP  = REDUCE ? ((1 << 20) + TABLE_BINS - 1) / TABLE_BINS : 0;

  logic                  s1_valid;
  logic [1:0]            s1_action;
  logic [ID_BITS-1:0]    s1_id;
  logic [VALUE_BITS-1:0] s1_val;
  logic [ADDR_W-1:0]     s1_addr [3];
  logic [7:0]            s1_quo [3];
  logic [ADDR_W-1:0]     s1_bin;

  logic [ADDR_W-1:0] addr_in [3];
  logic [31:0]       prod [3];
  logic [31:0]       rem32 [3];
  logic [IDX_W-1:0]  rem [3];
  logic [31:0]       id_ext;
  logic [31:0]       bin_ext;
  logic              in_range;
  logic              accept;

  assign addr_in[0] = in_ch.address_0;
  assign addr_in[1] = in_ch.address_1;
  assign addr_in[2] = in_ch.address_2;
  assign id_ext     = 32'(in_ch.element_id);

  assign push         = s1_valid && !full;
  assign in_ch.ready  = !s1_valid || !full;
  assign accept       = in_ch.valid && in_ch.ready;

  // quotient estimate in the first stage, remainder in the second
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k]  = 32'(addr_in[k]) * 32'(RECIP);
      rem32[k] = 32'(s1_addr[k]) - 32'(s1_quo[k]) * 32'(TABLE_BINS);
      rem[k]   = rem32[k][IDX_W-1:0];
    end
  end

  assign bin_ext  = 32'(s1_bin);
  assign in_range = bin_ext < 32'(TABLE_BINS);
  assign push_data = {s1_action, in_range, bin_ext[IDX_W-1:0], rem[2], rem[1], rem[0],
                      s1_id, s1_val};

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_action <= in_ch.action;
      s1_id     <= id_ext[ID_BITS-1:0];
      s1_val    <= in_ch.value[VALUE_BITS-1:0];
      s1_bin    <= in_ch.bin_index;
      for (int k = 0; k < 3; k++) begin
        s1_addr[k] <= addr_in[k];
        s1_quo[k]  <= prod[k][27:20];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ctins_queue.sv
// two-entry queue between front end and table engine
`default_nettype none

module ctins_queue #(
  parameter int WIDTH = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire  [WIDTH-1:0] push_data,
  output logic             full,
  input  wire              pop,
  output logic             valid,
  output logic [WIDTH-1:0] data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = count == 2'd2;
  assign valid = count != 2'd0;
  assign data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ctins_back.sv
// table engine: bin memories, displacement walk, reads, clearing sweep and result register
`default_nettype none

module ctins_back import ctins_pkg::*; #(
  parameter int TABLE_BINS = 1024,
  parameter int HASH_COUNT = 2,
  parameter int ID_BITS    = 16,
  parameter int VALUE_BITS = 64,
  parameter int IDX_W      = 10,
  parameter int ENTRY_W    = 3 + 4 * IDX_W + ID_BITS + VALUE_BITS
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  q_valid,
  input  wire  [ENTRY_W-1:0]   q_data,
  output logic                 q_pop,
  input  wire                  cfg_we,
  input  wire  [CFG_IDX_W-1:0] cfg_idx,
  input  wire  [CFG_DATA_W-1:0] cfg_data,
  ctins_out_if.source          out_ch
);

  localparam int DW    = ID_BITS + 3 * IDX_W + 2 + VALUE_BITS;
  localparam int O_ID  = VALUE_BITS;
  localparam int O_A0  = O_ID + ID_BITS;
  localparam int O_IDX = O_A0 + 3 * IDX_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_PROBE = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_KICK  = 6'b010000,
    ST_READ  = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [15:0] max_kicks;
  logic [7:0]  fill_byte;

  // element in hand
  logic [ID_BITS-1:0]    h_id;
  logic [IDX_W-1:0]      h_addr [3];
  logic [1:0]            h_pos;
  logic [VALUE_BITS-1:0] h_val;
  logic [ROUND_W-1:0]    round;
  logic [1:0]            rhi3;
  logic [1:0]            probe;
  logic [IDX_W-1:0]      cur_addr;
  logic [IDX_W-1:0]      kick_addr;
  logic                  rd_in_range;
  logic [IDX_W-1:0]      clr_cnt;
  logic                  clr_report;

  // result register
  logic                   o_valid;
  logic                   o_ok;
  logic [FIELD_ID_W-1:0]  o_drop;
  logic                   o_occ;
  logic [FIELD_ID_W-1:0]  o_sid;
  logic [FIELD_VAL_W-1:0] o_sval;

  // bin memories
  logic          vmem [TABLE_BINS];
  logic [DW-1:0] dmem [TABLE_BINS];
  logic          vq;
  logic [DW-1:0] dq;

  logic [IDX_W-1:0] rd_addr;
  logic             we_v;
  logic [IDX_W-1:0] wv_addr;
  logic             wv_data;
  logic             we_d;
  logic [IDX_W-1:0] wd_addr;
  logic [DW-1:0]    wd_data;

  logic                   res_we;
  logic                   res_ok;
  logic [FIELD_ID_W-1:0]  res_drop;
  logic                   res_occ;
  logic [FIELD_ID_W-1:0]  res_sid;
  logic [FIELD_VAL_W-1:0] res_sval;

  // queue entry fields
  logic [1:0]            e_action;
  logic                  e_inr;
  logic [IDX_W-1:0]      e_idx;
  logic [ID_BITS-1:0]    e_id;
  logic [VALUE_BITS-1:0] e_val;

  // occupant fields from the data memory
  logic [ID_BITS-1:0]    d_id;
  logic [1:0]            d_pos;
  logic [VALUE_BITS-1:0] d_val;

  logic        out_free;
  logic [1:0]  sel;
  logic [2:0]  sel_sum;
  logic [1:0]  addr_pick;
  logic [IDX_W-1:0] picked_addr;
  logic [16:0] round_inc;
  logic [31:0] d_id_ext;
  logic [63:0] fill_rep;
  logic [DW-1:0] hand_word;

  assign e_val    = q_data[VALUE_BITS-1:0];
  assign e_id     = q_data[O_ID +: ID_BITS];
  assign e_idx    = q_data[O_IDX +: IDX_W];
  assign e_inr    = q_data[O_IDX + IDX_W];
  assign e_action = q_data[O_IDX + IDX_W + 1 +: 2];

  assign d_val = dq[VALUE_BITS-1:0];
  assign d_pos = dq[VALUE_BITS +: 2];
  assign d_id  = dq[VALUE_BITS + 2 + 3 * IDX_W +: ID_BITS];

  assign d_id_ext  = 32'(d_id);
  assign fill_rep  = {8{fill_byte}};
  assign hand_word = {h_id, h_addr[2], h_addr[1], h_addr[0], h_pos, h_val};
  assign round_inc = 17'(round) + 17'd1;

  assign out_free = !o_valid || out_ch.ready;
  assign q_pop    = (state == ST_IDLE) && q_valid && out_free;

  // bin displaced this round: pos with two hashes, (pos xor round) mod 3 with three
  always_comb begin
    sel_sum = 3'({1'b0, round[1:0] ^ h_pos}) + 3'(rhi3);
    if (HASH_COUNT == 2) begin
      sel = {1'b0, h_pos[0]};
    end else if (sel_sum >= 3'd3) begin
      sel = 2'(sel_sum - 3'd3);
    end else begin
      sel = sel_sum[1:0];
    end
  end

  assign addr_pick   = (state == ST_CHECK) ? sel : probe;
  assign picked_addr = h_addr[addr_pick];

  // memory control and result
  always_comb begin
    rd_addr  = e_idx;
    we_v     = 1'b0;
    wv_addr  = cur_addr;
    wv_data  = 1'b1;
    we_d     = 1'b0;
    wd_addr  = cur_addr;
    wd_data  = hand_word;
    res_we   = 1'b0;
    res_ok   = 1'b0;
    res_drop = '0;
    res_occ  = 1'b0;
    res_sid  = '0;
    res_sval = '0;
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          if (e_action == ACT_INSERT) begin
            if (max_kicks == 16'd0) begin
              res_we   = 1'b1;
              res_drop = FIELD_ID_W'(e_id);
            end
          end else if (e_action == ACT_NOP) begin
            res_we = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        we_v    = 1'b1;
        wv_addr = clr_cnt;
        wv_data = 1'b0;
        if (clr_cnt == IDX_W'(TABLE_BINS - 1)) begin
          res_we = clr_report;
        end
      end
      ST_PROBE: begin
        rd_addr = picked_addr;
      end
      ST_CHECK: begin
        rd_addr = picked_addr;
        if (!vq) begin
          we_v    = 1'b1;
          we_d    = 1'b1;
          wd_data = {h_id, h_addr[2], h_addr[1], h_addr[0], probe, h_val};
          res_we  = 1'b1;
          res_ok  = 1'b1;
        end
      end
      ST_KICK: begin
        we_d    = 1'b1;
        wd_addr = kick_addr;
        if (round_inc >= 17'(max_kicks)) begin
          res_we   = 1'b1;
          res_drop = d_id_ext[FIELD_ID_W-1:0];
        end
      end
      ST_READ: begin
        res_we = 1'b1;
        if (rd_in_range && vq) begin
          res_occ  = 1'b1;
          res_sid  = d_id_ext[FIELD_ID_W-1:0];
          res_sval = FIELD_VAL_W'(d_val);
        end else begin
          res_sval = FIELD_VAL_W'(fill_rep[VALUE_BITS-1:0]);
        end
      end
      default: begin
        rd_addr = e_idx;
      end
    endcase
  end

  // bin memories with registered reads
  always_ff @(posedge clk) begin
    if (we_v) begin
      vmem[wv_addr] <= wv_data;
    end
    if (we_d) begin
      dmem[wd_addr] <= wd_data;
    end
    vq <= vmem[rd_addr];
    dq <= dmem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_kicks <= MAX_KICKS_RESET;
      fill_byte <= 8'd0;
    end else if (cfg_we) begin
      if (cfg_idx == REG_MAX_KICKS) begin
        max_kicks <= cfg_data;
      end else if (cfg_idx == REG_FILL_BYTE) begin
        fill_byte <= cfg_data[7:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (e_action)
              ACT_INSERT: begin
                if (max_kicks != 16'd0) begin
                  state <= ST_PROBE;
                end
              end
              ACT_READ:  state <= ST_READ;
              ACT_CLEAR: begin
                state      <= ST_CLEAR;
                clr_cnt    <= '0;
                clr_report <= 1'b1;
              end
              default:   state <= ST_IDLE;
            endcase
          end
        end
        ST_CLEAR: begin
          if (clr_cnt == IDX_W'(TABLE_BINS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + IDX_W'(1);
          end
        end
        ST_PROBE: state <= ST_CHECK;
        ST_CHECK: begin
          if (!vq) begin
            state <= ST_IDLE;
          end else if (probe != 2'(HASH_COUNT - 1)) begin
            state <= ST_PROBE;
          end else begin
            state <= ST_KICK;
          end
        end
        ST_KICK: begin
          if (round_inc >= 17'(max_kicks)) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_PROBE;
          end
        end
        ST_READ: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // element in hand and walk counters
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          h_id        <= e_id;
          h_val       <= e_val;
          h_pos       <= 2'd0;
          round       <= '0;
          rhi3        <= 2'd0;
          probe       <= 2'd0;
          rd_in_range <= e_inr;
          for (int k = 0; k < 3; k++) begin
            h_addr[k] <= q_data[O_A0 + k * IDX_W +: IDX_W];
          end
        end
      end
      ST_PROBE: cur_addr <= picked_addr;
      ST_CHECK: begin
        if (vq && probe != 2'(HASH_COUNT - 1)) begin
          probe <= probe + 2'd1;
        end
        kick_addr <= picked_addr;
      end
      ST_KICK: begin
        // occupant becomes the element in hand at its next candidate
        h_id  <= d_id;
        h_val <= d_val;
        h_pos <= (d_pos == 2'(HASH_COUNT - 1)) ? 2'd0 : d_pos + 2'd1;
        for (int k = 0; k < 3; k++) begin
          h_addr[k] <= dq[VALUE_BITS + 2 + k * IDX_W +: IDX_W];
        end
        probe <= 2'd0;
        round <= round_inc[ROUND_W-1:0];
        if (round[1:0] == 2'd3) begin
          rhi3 <= (rhi3 == 2'd2) ? 2'd0 : rhi3 + 2'd1;
        end
      end
      default: begin
        probe <= probe;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (res_we) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
    if (res_we) begin
      o_ok   <= res_ok;
      o_drop <= res_drop;
      o_occ  <= res_occ;
      o_sid  <= res_sid;
      o_sval <= res_sval;
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.insert_ok    = o_ok;
  assign out_ch.dropped_id   = o_drop;
  assign out_ch.occupied     = o_occ;
  assign out_ch.stored_id    = o_sid;
  assign out_ch.stored_value = o_sval;

endmodule

`default_nettype wire

FILE: rtl/cuckoo_table_insert_unit.sv
// top level of the cuckoo table insert unit
`default_nettype none

// Cuckoo hash placement engine over one table of TABLE_BINS bins held in memories with one
// write port, one read port and registered reads. Items pass a one-register front end that
// wraps candidate addresses into the table, then a two-entry queue, then the table engine,
// which runs one item at a time. In the engine every item is first taken from the queue; an
// insert then probes each candidate in a probe and a check state and, when all are full,
// displaces the occupant of one in a kick state; a read looks up its bin once, and a clear
// sweeps the occupancy memory one bin per cycle. After reset the engine clears every bin of
// the occupancy memory before it takes the first item; configuration writes are taken
// throughout. Configuration must be written only while the unit is idle; the unit itself
// does not enforce this.
module cuckoo_table_insert_unit import ctins_pkg::*; #(
  parameter int TABLE_BINS = 1024,
  parameter int HASH_COUNT = 2,
  parameter int VALUE_BITS = 64,
  parameter int ID_BITS    = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  ctins_in_if.sink              in_ch,
  ctins_out_if.source           out_ch,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_idx,
  input  wire  [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W   = $clog2(TABLE_BINS);
  localparam int ENTRY_W = 3 + 4 * IDX_W + ID_BITS + VALUE_BITS;

  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               full;
  logic               pop;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_data;

  ctins_front #(
    .TABLE_BINS (TABLE_BINS),
    .ID_BITS    (ID_BITS),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  ctins_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  ctins_back #(
    .TABLE_BINS (TABLE_BINS),
    .HASH_COUNT (HASH_COUNT),
    .ID_BITS    (ID_BITS),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (pop),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
